// ===== rtl/sequence_byte_loss_checker_macros.svh =====
// ----------------------------------------------------------------------------
// sequence byte loss checker assertion macros
// shared concurrent assertion forms used by the checker module
// ----------------------------------------------------------------------------
`ifndef SEQUENCE_BYTE_LOSS_CHECKER_MACROS_SVH
`define SEQUENCE_BYTE_LOSS_CHECKER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define SBL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbl assertion failed");

// next-cycle implication, disabled while reset is asserted
`define SBL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbl assertion failed");

`endif

// ===== rtl/sbl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbl_pkg
// types and constants shared by the sequence byte loss checker modules
// ----------------------------------------------------------------------------
package sbl_pkg;

    // counter width inside the block, results show the low 32 bits
    localparam int COUNT_BITS     = 32;
    localparam int OUT_BITS       = 32;
    localparam int SYNC_RUN_BITS  = 4;
    localparam int RUN_LEN_BITS   = 4;

    localparam logic [SYNC_RUN_BITS-1:0] SYNC_RUN_RESET = 4'd4;
    localparam logic [RUN_LEN_BITS-1:0]  RUN_LEN_MAX    = 4'd15;

    // command queue between front and back
    localparam int CQ_DEPTH  = 2;
    localparam int CQ_PTR_W  = $clog2(CQ_DEPTH);
    localparam int CQ_CNT_W  = $clog2(CQ_DEPTH + 1);

    typedef logic [COUNT_BITS-1:0] count_t;

    typedef enum logic
    {
        OP_BYTE  = 1'b0,
        OP_CLEAR = 1'b1
    } op_t;

    typedef enum logic [2:0]
    {
        CMD_CLEAR,
        CMD_HOLD,
        CMD_SYNC,
        CMD_MATCH,
        CMD_BREAK
    } cmd_kind_t;

    typedef struct packed
    {
        op_t        op;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed
    {
        logic                synced;
        logic                in_order;
        logic [7:0]          gap;
        logic [OUT_BITS-1:0] bytes_count;
        logic [OUT_BITS-1:0] overrun_count;
        logic [OUT_BITS-1:0] lost_count;
        logic [OUT_BITS-1:0] max_burst_len;
    } out_item_t;

    // classified work handed from front to back
    typedef struct packed
    {
        cmd_kind_t  kind;
        logic       synced;
        logic [7:0] gap;
    } cmd_t;

    // low 32 bits of a counter, zero extended when the counter is narrower
    function automatic logic [OUT_BITS-1:0] to_out(input count_t c);
        logic [63:0] wide;
        wide = 64'(c);
        return wide[OUT_BITS-1:0];
    endfunction

endpackage

// ===== rtl/sbl_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbl_front
// accepts bytes, tracks sync and the expected byte, classifies each transaction
// ----------------------------------------------------------------------------
module sbl_front
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [sbl_pkg::SYNC_RUN_BITS-1:0]      cfg_data,
    input  logic                                   accept,
    input  sbl_pkg::in_item_t                      in_item,
    output sbl_pkg::cmd_t                          cmd
);
    import sbl_pkg::*;

    logic [SYNC_RUN_BITS-1:0] sync_run_reg;
    logic                     sync_done_reg, sync_done_next;
    logic                     have_prev_reg, have_prev_next;
    logic [7:0]               prev_byte_reg, prev_byte_next;
    logic [RUN_LEN_BITS-1:0]  run_len_reg, run_len_next;
    logic [7:0]               expected_reg, expected_next;
    logic [RUN_LEN_BITS-1:0]  run_len_inc;
    logic [7:0]               delta;

    always_comb
    begin
        run_len_inc    = (run_len_reg < RUN_LEN_MAX) ? run_len_reg + 1'b1 : run_len_reg;
        delta          = in_item.rx_byte - expected_reg;
        sync_done_next = sync_done_reg;
        have_prev_next = have_prev_reg;
        prev_byte_next = prev_byte_reg;
        run_len_next   = run_len_reg;
        expected_next  = expected_reg;
        cmd.kind       = CMD_HOLD;
        cmd.synced     = sync_done_reg;
        cmd.gap        = 8'd0;
        priority if (in_item.op == OP_CLEAR)
        begin
            sync_done_next = 1'b0;
            have_prev_next = 1'b0;
            prev_byte_next = 8'd0;
            run_len_next   = '0;
            expected_next  = 8'd0;
            cmd.kind       = CMD_CLEAR;
            cmd.synced     = 1'b0;
        end
        else if (!sync_done_reg)
        begin
            prev_byte_next = in_item.rx_byte;
            if (have_prev_reg && (in_item.rx_byte == prev_byte_reg + 8'd1))
            begin
                run_len_next = run_len_inc;
                if (run_len_inc >= sync_run_reg)
                begin
                    expected_next  = in_item.rx_byte + 8'd1;
                    sync_done_next = 1'b1;
                    cmd.kind       = CMD_SYNC;
                    cmd.synced     = 1'b1;
                end
            end
            else
            begin
                have_prev_next = 1'b1;
                run_len_next   = RUN_LEN_BITS'(1);
            end
        end
        else if (delta == 8'd0)
        begin
            expected_next = expected_reg + 8'd1;
            cmd.kind      = CMD_MATCH;
        end
        else
        begin
            expected_next = in_item.rx_byte + 8'd1;
            cmd.kind      = CMD_BREAK;
            cmd.gap       = delta;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_run_reg  <= SYNC_RUN_RESET;
            sync_done_reg <= 1'b0;
            have_prev_reg <= 1'b0;
            prev_byte_reg <= 8'd0;
            run_len_reg   <= '0;
            expected_reg  <= 8'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                sync_run_reg <= cfg_data;
            end
            if (accept)
            begin
                sync_done_reg <= sync_done_next;
                have_prev_reg <= have_prev_next;
                prev_byte_reg <= prev_byte_next;
                run_len_reg   <= run_len_next;
                expected_reg  <= expected_next;
            end
        end
    end

endmodule

// ===== rtl/sbl_cmd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbl_cmd_queue
// short first-in first-out queue of classified commands between front and back
// ----------------------------------------------------------------------------
module sbl_cmd_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  sbl_pkg::cmd_t  wr_data,
    output logic           full,
    input  logic           rd_en,
    output logic           rd_valid,
    output sbl_pkg::cmd_t  rd_data
);
    import sbl_pkg::*;

    cmd_t                entry_reg [CQ_DEPTH];
    logic [CQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CQ_CNT_W-1:0] count_reg, count_next;
    logic                do_wr, do_rd;

    assign full     = (count_reg == CQ_CNT_W'(CQ_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/sbl_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbl_back
// applies commands to the loss counters and holds the result register
// ----------------------------------------------------------------------------
module sbl_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  sbl_pkg::cmd_t       cmd,
    output logic                cmd_take,
    output logic                empty,
    input  logic                pop,
    output sbl_pkg::out_item_t  out_item
);
    import sbl_pkg::*;

    count_t    received_reg, received_next;
    count_t    breaks_reg, breaks_next;
    count_t    lost_reg, lost_next;
    count_t    longest_reg, longest_next;
    count_t    current_reg, current_next;
    count_t    current_inc;
    logic      out_valid_reg, out_valid_next;
    out_item_t out_item_reg, out_item_next;

    assign empty    = !out_valid_reg;
    assign out_item = out_item_reg;
    assign cmd_take = cmd_valid && (!out_valid_reg || pop);

    always_comb
    begin
        current_inc   = current_reg + 1'b1;
        received_next = received_reg;
        breaks_next   = breaks_reg;
        lost_next     = lost_reg;
        longest_next  = longest_reg;
        current_next  = current_reg;
        unique case (cmd.kind)
            CMD_CLEAR, CMD_SYNC:
            begin
                received_next = '0;
                breaks_next   = '0;
                lost_next     = '0;
                longest_next  = '0;
                current_next  = '0;
            end
            CMD_MATCH:
            begin
                received_next = received_reg + 1'b1;
                current_next  = current_inc;
                if (current_inc > longest_reg)
                begin
                    longest_next = current_inc;
                end
            end
            CMD_BREAK:
            begin
                received_next = received_reg + 1'b1;
                breaks_next   = breaks_reg + 1'b1;
                lost_next     = lost_reg + COUNT_BITS'(cmd.gap);
                current_next  = COUNT_BITS'(1);
            end
            default:
            begin
            end
        endcase
        out_item_next.synced        = cmd.synced;
        out_item_next.in_order      = (cmd.kind == CMD_MATCH);
        out_item_next.gap           = cmd.gap;
        out_item_next.bytes_count   = to_out(received_next);
        out_item_next.overrun_count = to_out(breaks_next);
        out_item_next.lost_count    = to_out(lost_next);
        out_item_next.max_burst_len = to_out(longest_next);
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            out_item_reg <= out_item_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            received_reg  <= '0;
            breaks_reg    <= '0;
            lost_reg      <= '0;
            longest_reg   <= '0;
            current_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cmd_take)
            begin
                received_reg <= received_next;
                breaks_reg   <= breaks_next;
                lost_reg     <= lost_next;
                longest_reg  <= longest_next;
                current_reg  <= current_next;
            end
        end
    end

endmodule

// ===== rtl/sequence_byte_loss_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequence_byte_loss_checker
// checks a received byte stream against an incrementing modulo-256 pattern
// ----------------------------------------------------------------------------
// one transaction in gives exactly one result transaction out. a byte with
// op = byte first hunts for sync_run consecutive +1 bytes; the byte that
// completes the run reports synced = 1 and clears all metrics. after that each
// byte is compared with the expected value and the result carries in_order,
// the gap on a break, and the byte, overrun, lost and longest-burst counters
// as they stand after the byte. op = clear returns everything to the reset
// state (sync_run keeps its value) and reports all zeros. the block takes one
// transaction per clock while full is low, and its result reaches the ports
// through the command queue entry written at the accepting edge and then the
// back-stage result register. with pop held low, three transactions wait (two
// in the command queue, one in the result register) before full rises.
// sync_run may be written only while no transaction is in flight.
// ----------------------------------------------------------------------------
module sequence_byte_loss_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration: sync run length
    input  logic                                cfg_we,
    input  logic [sbl_pkg::SYNC_RUN_BITS-1:0]   cfg_data,
    // input side, queue style
    input  logic                                push,
    output logic                                full,
    input  sbl_pkg::in_item_t                   in_item,
    // result side, queue style
    output logic                                empty,
    input  logic                                pop,
    output sbl_pkg::out_item_t                  out_item
);
    import sbl_pkg::*;

    cmd_t front_cmd;
    cmd_t back_cmd;
    logic accept;
    logic back_valid;
    logic back_take;

    // a transaction is taken whenever the command queue has room
    assign accept = push && !full;

    // front: sync search, expected byte tracking, classification
    sbl_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .accept   (accept),
        .in_item  (in_item),
        .cmd      (front_cmd)
    );

    // decouples the front from result back-pressure
    sbl_cmd_queue u_cmd_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (accept),
        .wr_data  (front_cmd),
        .full     (full),
        .rd_en    (back_take),
        .rd_valid (back_valid),
        .rd_data  (back_cmd)
    );

    // back: counters and result register
    sbl_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (back_valid),
        .cmd       (back_cmd),
        .cmd_take  (back_take),
        .empty     (empty),
        .pop       (pop),
        .out_item  (out_item)
    );

endmodule

// ===== rtl/sbl_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbl_checker
// port-level assertions for the sequence byte loss checker
// ----------------------------------------------------------------------------
`include "sequence_byte_loss_checker_macros.svh"

module sbl_checker
(
    input logic                                clk,
    input logic                                rst_n,
    input logic                                cfg_we,
    input logic [sbl_pkg::SYNC_RUN_BITS-1:0]   cfg_data,
    input logic                                push,
    input logic                                full,
    input sbl_pkg::in_item_t                   in_item,
    input logic                                empty,
    input logic                                pop,
    input sbl_pkg::out_item_t                  out_item
);
    import sbl_pkg::*;

    // a waiting result that is not taken stays put
    `SBL_ASSERT_NEXT(a_result_held, clk, rst_n, !empty && !pop, !empty && $stable(out_item))

    // before sync every metric is zero and nothing is checked
    `SBL_ASSERT_SAME(a_presync_zero, clk, rst_n, !empty && !out_item.synced,
        out_item.bytes_count == '0 && out_item.overrun_count == '0 &&
        out_item.lost_count == '0 && out_item.max_burst_len == '0 &&
        !out_item.in_order && out_item.gap == 8'd0)

    // an in-order byte has no gap, a gap only comes from a checked break
    `SBL_ASSERT_SAME(a_gap_consistent, clk, rst_n,
        !empty && (out_item.in_order || out_item.gap != 8'd0),
        out_item.synced && !(out_item.in_order && out_item.gap != 8'd0))

endmodule

bind sequence_byte_loss_checker sbl_checker u_sbl_checker (.*);

// ===== verif/sequence_byte_loss_checker_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequence_byte_loss_checker_tb
// self-checking regression for the incrementing-pattern byte loss checker.
// a built-in pattern tracker predicts every result transaction from the
// accepted input transactions. directed cases come first, then random
// pattern streams under several sync_run settings, with random idling on
// both sides, a long result hold-off and a full drain pause.
// ----------------------------------------------------------------------------
module sequence_byte_loss_checker_tb;

    import sbl_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 5;
    localparam int IDLE_PCT      = 11;
    localparam int HOLD_CYCLES   = 150;
    // result passes through the command queue and the result register, leave a little margin
    localparam int SETTLE_CYCLES = 4;
    localparam int LIMIT_CYCLES  = 200000;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [SYNC_RUN_BITS-1:0] cfg_data;
    logic                     push;
    logic                     full;
    in_item_t                 in_item;
    logic                     empty;
    logic                     pop;
    out_item_t                out_item;

    sequence_byte_loss_checker dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .push     (push),
        .full     (full),
        .in_item  (in_item),
        .empty    (empty),
        .pop      (pop),
        .out_item (out_item)
    );

    // ------------------------------------------------------------------------
    // pattern tracker state, mirrors what the block should hold
    // ------------------------------------------------------------------------
    logic [SYNC_RUN_BITS-1:0] trk_sync_run;
    logic                     trk_synced;
    logic                     trk_have_prev;
    logic [7:0]               trk_prev;
    logic [RUN_LEN_BITS-1:0]  trk_run;
    logic [7:0]               trk_next;
    count_t                   trk_bytes;
    count_t                   trk_breaks;
    count_t                   trk_lost;
    count_t                   trk_longest;
    count_t                   trk_burst;

    // loss reports still owed by the block, oldest first
    out_item_t pending_reports[$];

    int  errors        = 0;
    int  cycle_count   = 0;
    // both sides stop idling while set
    bit  no_idle       = 1'b0;
    // asks the result side for one long hold-off
    bit  hold_results  = 1'b0;

    // ------------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // run limit, a stuck handshake ends here
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // pattern tracker
    // ------------------------------------------------------------------------
    // metrics only, sync hunt state is left alone
    function automatic void clear_loss_metrics();
        trk_bytes   = '0;
        trk_breaks  = '0;
        trk_lost    = '0;
        trk_longest = '0;
        trk_burst   = '0;
    endfunction

    // everything but the sync_run register
    function automatic void clear_pattern_state();
        trk_synced    = 1'b0;
        trk_have_prev = 1'b0;
        trk_prev      = '0;
        trk_run       = '0;
        trk_next      = '0;
        clear_loss_metrics();
    endfunction

    // advances the tracker by one transaction and returns the loss report
    function automatic out_item_t predict_loss_report(input in_item_t t);
        out_item_t  r;
        logic [7:0] step_val;
        logic [7:0] delta;
        r        = '0;
        step_val = trk_prev + 8'd1;
        if (t.op == OP_CLEAR)
        begin
            clear_pattern_state();
        end
        else if (!trk_synced)
        begin
            // hunting for a run of +1 bytes
            if (!trk_have_prev)
            begin
                trk_have_prev = 1'b1;
                trk_prev      = t.rx_byte;
                trk_run       = RUN_LEN_BITS'(1);
            end
            else if (t.rx_byte == step_val)
            begin
                // run length saturates instead of wrapping
                if (trk_run < RUN_LEN_MAX)
                    trk_run = trk_run + 1'b1;
                trk_prev = t.rx_byte;
                if (trk_run >= trk_sync_run)
                begin
                    // byte that completes the run is not checked or counted
                    trk_next   = t.rx_byte + 8'd1;
                    trk_synced = 1'b1;
                    clear_loss_metrics();
                end
            end
            else
            begin
                trk_prev = t.rx_byte;
                trk_run  = RUN_LEN_BITS'(1);
            end
        end
        else
        begin
            delta = t.rx_byte - trk_next;
            if (delta == 8'd0)
            begin
                r.in_order = 1'b1;
                trk_burst  = trk_burst + 1'b1;
                if (trk_burst > trk_longest)
                    trk_longest = trk_burst;
                trk_next = trk_next + 8'd1;
            end
            else
            begin
                // sequence break: count it, add the gap, resync on this byte
                r.gap      = delta;
                trk_breaks = trk_breaks + 1'b1;
                trk_lost   = trk_lost + count_t'(delta);
                trk_burst  = count_t'(1);
                trk_next   = t.rx_byte + 8'd1;
            end
            trk_bytes = trk_bytes + 1'b1;
        end
        r.synced        = trk_synced;
        r.bytes_count   = OUT_BITS'(trk_bytes);
        r.overrun_count = OUT_BITS'(trk_breaks);
        r.lost_count    = OUT_BITS'(trk_lost);
        r.max_burst_len = OUT_BITS'(trk_longest);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // result side: pop with random idling, one long hold-off on request
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int hold_left;
        hold_left = 0;
        pop       = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_results)
            begin
                hold_left    = HOLD_CYCLES;
                hold_results = 1'b0;
            end
            if (hold_left > 0)
            begin
                pop       <= 1'b0;
                hold_left = hold_left - 1;
            end
            else if (no_idle)
                pop <= 1'b1;
            else
                pop <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------------
    // result checking against the oldest pending report
    // ------------------------------------------------------------------------
    function automatic void check_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got)
        begin
            $error("%s expected %0d actual %0d", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin : report_check
        out_item_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_reports.size() == 0)
            begin
                $error("result transaction with no report pending");
                errors++;
            end
            else
            begin
                want = pending_reports.pop_front();
                check_field("synced",        want.synced,        out_item.synced);
                check_field("in_order",      want.in_order,      out_item.in_order);
                check_field("gap",           want.gap,           out_item.gap);
                check_field("bytes_count",   want.bytes_count,   out_item.bytes_count);
                check_field("overrun_count", want.overrun_count, out_item.overrun_count);
                check_field("lost_count",    want.lost_count,    out_item.lost_count);
                check_field("max_burst_len", want.max_burst_len, out_item.max_burst_len);
            end
        end
    end

    // ------------------------------------------------------------------------
    // input side helpers, all entered and left at a falling edge
    // ------------------------------------------------------------------------
    // offers one transaction; push stays high on return so back-to-back
    // transactions need not drop push in between
    task automatic send_item(input op_t op, input logic [7:0] rx);
        in_item_t t;
        t.op      = op;
        t.rx_byte = rx;
        while (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push    <= 1'b1;
        in_item <= t;
        @(posedge clk);
        while (full)
            @(posedge clk);
        pending_reports.push_back(predict_loss_report(t));
        @(negedge clk);
    endtask

    task automatic send_byte(input logic [7:0] rx);
        send_item(OP_BYTE, rx);
    endtask

    // stops sending and waits for every pending report, then lets the
    // pipeline settle
    task automatic wait_until_drained();
        push <= 1'b0;
        while (pending_reports.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // register writes happen only with nothing in flight
    task automatic write_sync_run(input logic [SYNC_RUN_BITS-1:0] value);
        wait_until_drained();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we       <= 1'b0;
        trk_sync_run = value;
    endtask

    // mostly a clean incrementing stream from a random start; break_pct
    // percent of bytes jump ahead, repeat the last byte or are pure noise,
    // clear_pct percent are clear ops with a random byte
    task automatic send_pattern_stream(input int count, input int break_pct,
                                       input int clear_pct);
        logic [7:0] next_val;
        int         roll;
        next_val = 8'($urandom);
        repeat (count)
        begin
            roll = $urandom_range(99);
            if (roll < clear_pct)
                send_item(OP_CLEAR, 8'($urandom));
            else
            begin
                if (roll < clear_pct + break_pct)
                begin
                    case ($urandom_range(2))
                        0:       next_val = next_val + 8'($urandom_range(255, 1));
                        1:       next_val = next_val - 8'd1;
                        default: next_val = 8'($urandom);
                    endcase
                end
                send_byte(next_val);
                next_val = next_val + 8'd1;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // directed tests, reset value of sync_run
    // ------------------------------------------------------------------------
    // pre-sync bytes, a broken run, the byte that completes the run, then in-order bytes
    task automatic test_sync_hunt();
        send_byte(8'd10);
        send_byte(8'd11);
        send_byte(8'd12);
        send_byte(8'd20);
        send_byte(8'd21);
        send_byte(8'd22);
        send_byte(8'd23);
        send_byte(8'd24);
        send_byte(8'd25);
    endtask

    // jump ahead, repeated byte (gap 255), jump to 0xff, in-order wrap, jump ahead
    task automatic test_breaks_and_wrap();
        send_byte(8'h30);
        send_byte(8'h30);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h01);
        send_byte(8'h81);
    endtask

    // clear ignores its byte; first byte after clear only starts the run,
    // then a run that wraps through 0xff reaches sync
    task automatic test_clear_and_wrapped_sync();
        send_item(OP_CLEAR, 8'hFF);
        send_byte(8'h00);
        send_item(OP_CLEAR, 8'h00);
        send_byte(8'hFE);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h01);
        send_byte(8'h02);
    endtask

    // ------------------------------------------------------------------------
    // random tests
    // ------------------------------------------------------------------------
    // zero and one sync on the first +1 step, 15 needs a saturated run
    task automatic test_sync_run_extremes();
        write_sync_run(4'd0);
        send_pattern_stream(60, 10, 3);
        write_sync_run(4'd1);
        send_pattern_stream(50, 10, 3);
        write_sync_run(4'd15);
        send_pattern_stream(100, 2, 1);
        write_sync_run(4'd2);
        send_pattern_stream(80, 12, 4);
    endtask

    // long stretch with neither side idling
    task automatic test_steady_stream();
        write_sync_run(4'd7);
        no_idle = 1'b1;
        send_pattern_stream(120, 6, 2);
        wait_until_drained();
        no_idle = 1'b0;
    endtask

    // result side holds off while the input keeps offering, so the block
    // fills up and raises full; afterwards the input pauses for a drain
    task automatic test_backpressure();
        write_sync_run(4'd3);
        hold_results = 1'b1;
        send_pattern_stream(40, 8, 2);
        wait_until_drained();
    endtask

    // several random settings with noisier streams
    task automatic test_random_settings();
        repeat (4)
        begin
            write_sync_run(4'($urandom_range(15, 0)));
            send_pattern_stream(50, 15, 5);
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin : regression
        rst_n    = 1'b0;
        cfg_we   = 1'b0;
        cfg_data = '0;
        push     = 1'b0;
        in_item  = '0;
        trk_sync_run = SYNC_RUN_RESET;
        clear_pattern_state();
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_sync_hunt();
        test_breaks_and_wrap();
        test_clear_and_wrapped_sync();
        test_sync_run_extremes();
        test_steady_stream();
        test_backpressure();
        test_random_settings();

        wait_until_drained();
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
